// ----- sv/assert_macros.svh -----
// Assertion macros used by the even and prime counter datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define EPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define EPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ----- sv/epc_pkg.sv -----
// Shared types and constants for the even and prime counter.
package epc_pkg;

    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 15;
    localparam int COUNT_MAX        = 2**COUNT_W - 1;
    localparam int MAX_ELEMENTS_DEF = 16384;

    // Trial divisors are odd and stay below 2^16 (sqrt of 2^31 is about 46341).
    localparam int DIVISOR_W = 16;
    localparam int DSQ_W     = 32;
    // One restoring step per dividend bit; the sign bit is never divided.
    localparam int DIV_STEPS = VALUE_W - 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TEST,
        ST_DIV,
        ST_REM,
        ST_DONE
    } epc_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture the accepted request
        logic init_div;   // first trial divisor: 3
        logic start_div;  // begin remainder of value by divisor
        logic div_step;   // one restoring division step
        logic next_div;   // advance to the next odd divisor
        logic commit;     // write the result register, update counts
        logic prime;      // primality verdict carried with commit
    } epc_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic below_two;  // negative, zero or one
        logic below_four; // with below_two clear: two or three
        logic even;
        logic dsq_over;   // divisor squared exceeds value
        logic rem_zero;
        logic last_step;
        logic out_free;   // result register can take a new result
    } epc_status_t;

endpackage

// ----- sv/epc_datapath.sv -----
// Datapath: request capture, shared remainder unit, counters and result register.
`include "assert_macros.svh"

module epc_datapath #(
    parameter int MAX_ELEMENTS = epc_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  epc_pkg::epc_cmd_t                   cmd,
    output epc_pkg::epc_status_t                status,
    input  logic signed [epc_pkg::VALUE_W-1:0]  s_value,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_even,
    output logic                                m_is_prime,
    output logic        [epc_pkg::COUNT_W-1:0]  m_even_count,
    output logic        [epc_pkg::COUNT_W-1:0]  m_prime_count,
    output logic                                m_end_of_matrix
);
    import epc_pkg::*;

    localparam int LimitInt = (MAX_ELEMENTS > COUNT_MAX) ? COUNT_MAX : MAX_ELEMENTS;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LimitInt);

    logic [VALUE_W-1:0]   value_reg;
    logic                 last_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DSQ_W-1:0]     dsq_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [VALUE_W-2:0]   shf_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIVISOR_W:0]   trial;

    logic [COUNT_W-1:0]   evens_reg;
    logic [COUNT_W-1:0]   primes_reg;
    logic [COUNT_W-1:0]   evens_next;
    logic [COUNT_W-1:0]   primes_next;

    logic                 m_valid_reg;
    logic                 m_is_even_reg;
    logic                 m_is_prime_reg;
    logic [COUNT_W-1:0]   m_even_count_reg;
    logic [COUNT_W-1:0]   m_prime_count_reg;
    logic                 m_end_reg;

    // Status toward the controller
    always_comb begin
        status.below_two  = value_reg[VALUE_W-1] || (value_reg[VALUE_W-2:1] == '0);
        status.below_four = (value_reg[VALUE_W-2:2] == '0);
        status.even       = !value_reg[0];
        status.dsq_over   = dsq_reg > {1'b0, value_reg[VALUE_W-2:0]};
        status.rem_zero   = (rem_reg == '0);
        status.last_step  = (step_reg == STEP_W'(DIV_STEPS - 1));
        status.out_free   = !m_valid_reg || m_ready;
    end

    // Restoring step: remainder stays below the divisor
    always_comb begin
        trial = {rem_reg, shf_reg[VALUE_W-2]};
        if (trial >= {1'b0, divisor_reg}) begin
            rem_next = DIVISOR_W'(trial - {1'b0, divisor_reg});
        end else begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    // Saturating counts including the current element
    always_comb begin
        evens_next  = evens_reg;
        primes_next = primes_reg;
        if (!value_reg[0]) begin
            evens_next = (evens_reg >= COUNT_LIMIT) ? COUNT_LIMIT : evens_reg + 1'b1;
        end
        if (cmd.prime) begin
            primes_next = (primes_reg >= COUNT_LIMIT) ? COUNT_LIMIT : primes_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_value;
            last_reg  <= s_last;
        end
        if (cmd.init_div) begin
            divisor_reg <= DIVISOR_W'(3);
            dsq_reg     <= DSQ_W'(9);
        end else if (cmd.next_div) begin
            divisor_reg <= divisor_reg + DIVISOR_W'(2);
            dsq_reg     <= dsq_reg + DSQ_W'({divisor_reg, 2'b00}) + DSQ_W'(4);
        end
        if (cmd.start_div) begin
            rem_reg  <= '0;
            shf_reg  <= value_reg[VALUE_W-2:0];
            step_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            shf_reg  <= {shf_reg[VALUE_W-3:0], 1'b0};
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.commit) begin
            m_is_even_reg     <= !value_reg[0];
            m_is_prime_reg    <= cmd.prime;
            m_even_count_reg  <= evens_next;
            m_prime_count_reg <= primes_next;
            m_end_reg         <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evens_reg   <= '0;
            primes_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                evens_reg  <= last_reg ? '0 : evens_next;
                primes_reg <= last_reg ? '0 : primes_next;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_is_even       = m_is_even_reg;
    assign m_is_prime      = m_is_prime_reg;
    assign m_even_count    = m_even_count_reg;
    assign m_prime_count   = m_prime_count_reg;
    assign m_end_of_matrix = m_end_reg;

    `EPC_ASSERT(a_commit_slot_free, cmd.commit |-> (!m_valid_reg || m_ready), "commit over a pending result")
    `EPC_ASSERT(a_rem_below_div, cmd.div_step |=> (rem_reg < divisor_reg), "remainder not below divisor")
    `EPC_ASSERT(a_divisor_odd, (cmd.next_div || cmd.init_div) |=> divisor_reg[0], "even trial divisor")
    `EPC_ASSERT(a_count_limit, m_valid_reg |-> (m_even_count <= COUNT_LIMIT && m_prime_count <= COUNT_LIMIT), "count above limit")

endmodule

// ----- sv/epc_controller.sv -----
// Controller: sequences the trial division for one request at a time.
module epc_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  epc_pkg::epc_status_t status,
    output epc_pkg::epc_cmd_t    cmd
);
    import epc_pkg::*;

    epc_state_t state_reg;
    epc_state_t state_next;
    logic       prime_reg;
    logic       prime_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            prime_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            prime_reg <= prime_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        prime_next = prime_reg;
        cmd        = '0;
        cmd.prime  = prime_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.below_two) begin
                    prime_next = 1'b0;
                    state_next = ST_DONE;
                end else if (status.below_four) begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end else if (status.even) begin
                    prime_next = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    cmd.init_div = 1'b1;
                    state_next   = ST_TEST;
                end
            end
            ST_TEST: begin
                if (status.dsq_over) begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.last_step) begin
                    state_next = ST_REM;
                end
            end
            ST_REM: begin
                if (status.rem_zero) begin
                    prime_next = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_TEST;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/even_and_prime_counter_core.sv -----
// Top level of the even and prime counter: controller plus datapath.
//
// Input channel s_*: one request per matrix element, a signed 32-bit value
// and a last flag. Result channel m_*: one result per request, in order,
// with the even and prime flags, the running saturating counts of this
// matrix including the element, and end_of_matrix (copy of last).
// Counts clear after the result of a last element.
//
// Negative, zero, one, two, three and even values go from the check state
// to the done state; the next request is taken once the controller is idle.
// An odd value v >= 5 is divided by 3, 5, 7 and on by odd divisors up to
// sqrt(v), stopping at the first that divides it; each trial divisor takes
// a bound test, 31 division steps in the shared bit-serial remainder unit
// and a remainder test. Worst case, a prime near 2^31: about 23170 divisors.
// One request is in work at a time; s_ready is high only while idle.
//
// Result register: a finished result waits there while m_ready is low; the
// next request is accepted and worked on meanwhile, and only its commit
// waits for the register to empty. Reset (aresetn, synchronous, active low)
// clears the counts, the result valid and the controller.
module even_and_prime_counter_core #(
    parameter int MAX_ELEMENTS = epc_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [epc_pkg::VALUE_W-1:0]  s_value,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_even,
    output logic                                m_is_prime,
    output logic        [epc_pkg::COUNT_W-1:0]  m_even_count,
    output logic        [epc_pkg::COUNT_W-1:0]  m_prime_count,
    output logic                                m_end_of_matrix
);
    import epc_pkg::*;

    epc_cmd_t    cmd;
    epc_status_t status;

    // Sequencer: accepts a request, then walks the trial divisors
    epc_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Value capture, remainder unit, counters, result register
    epc_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_value         (s_value),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_even       (m_is_even),
        .m_is_prime      (m_is_prime),
        .m_even_count    (m_even_count),
        .m_prime_count   (m_prime_count),
        .m_end_of_matrix (m_end_of_matrix)
    );

endmodule
